### hdl/keht_pkg.sv
package keht_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_NUM_WINDOWS = 4;
    localparam int DEF_NUM_TYPES   = 4;

    localparam int WSLOTS = 4;
    localparam int TSLOTS = 4;

    localparam int KEY_W      = 31;
    localparam int DATE_W     = 14;
    localparam int TYPE_W     = 2;
    localparam int POS_W      = 10;
    localparam int SLOT_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 32;
    localparam int FLOOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [DATE_W-1:0]  BOUND_A_RST     = DATE_W'(516);
    localparam logic [DATE_W-1:0]  BOUND_B_RST     = DATE_W'(616);
    localparam logic [DATE_W-1:0]  BOUND_C_RST     = DATE_W'(716);
    localparam logic [DATE_W-1:0]  BOUND_D_RST     = DATE_W'(816);
    localparam logic [TYPE_W-1:0]  BOUGHT_CODE_RST = TYPE_W'(1);
    localparam logic [FLOOR_W-1:0] TOTAL_FLOOR_RST = FLOOR_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_BOUND_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_C     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUGHT_CODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FLOOR = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNUSED = 2'd2;

    localparam logic [0:0] FUNC_RECORD = 1'b0;
    localparam logic [0:0] FUNC_READ   = 1'b1;

    typedef logic [TSLOTS-1:0][CNT_W-1:0] win_row_t;

    typedef struct packed {
        logic key_we;
        logic cnt_we;
        logic win_we;
    } store_we_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

### hdl/keht_store.sv
module keht_store #(
    parameter int TABLE_DEPTH = keht_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                   clk,
    input  keht_pkg::store_we_t                    we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]         key_raddr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]         key_waddr,
    input  logic [keht_pkg::KEY_W-1:0]             key_wdata,
    output logic [keht_pkg::KEY_W-1:0]             key_rdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0]         cnt_addr,
    input  logic [keht_pkg::CNT_W-1:0]             tot_wdata,
    input  logic [keht_pkg::CNT_W-1:0]             bgt_wdata,
    output logic [keht_pkg::CNT_W-1:0]             tot_rdata,
    output logic [keht_pkg::CNT_W-1:0]             bgt_rdata,
    input  logic [$clog2(TABLE_DEPTH)+1:0]         win_addr,
    input  keht_pkg::win_row_t                     win_wdata,
    output keht_pkg::win_row_t                     win_rdata
);
    import keht_pkg::*;

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] tot_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] bgt_mem [TABLE_DEPTH];
    win_row_t         win_mem [TABLE_DEPTH*WSLOTS];

    always_ff @(posedge clk)
    begin
        if (we.key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.cnt_we)
        begin
            tot_mem[cnt_addr] <= tot_wdata;
            bgt_mem[cnt_addr] <= bgt_wdata;
        end
        tot_rdata <= tot_mem[cnt_addr];
        bgt_rdata <= bgt_mem[cnt_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.win_we)
        begin
            win_mem[win_addr] <= win_wdata;
        end
        win_rdata <= win_mem[win_addr];
    end

endmodule

### hdl/keyed_event_histogram_table.sv
// Record transaction: a key search over the N used entries (one compare per cycle on the key
// memory read port), then a clear of every window row of a new entry, then a read and a
// write-back of the counters. Read transaction: each window row is read, then emitted.
// One transaction is in flight at a time; a finished result waits in the output register.
// Reset clears the control state, the fill count and the configuration registers; the memories
// are not swept, since entries at or above the fill count are never read.
module keyed_event_histogram_table #(
    parameter int TABLE_DEPTH = keht_pkg::DEF_TABLE_DEPTH,
    parameter int NUM_WINDOWS = keht_pkg::DEF_NUM_WINDOWS,
    parameter int NUM_TYPES   = keht_pkg::DEF_NUM_TYPES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [keht_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [keht_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               func,
    input  logic [keht_pkg::KEY_W-1:0]         item_key,
    input  logic [keht_pkg::TYPE_W-1:0]        action_type,
    input  logic [keht_pkg::DATE_W-1:0]        event_date,
    input  logic [keht_pkg::POS_W-1:0]         read_index,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [keht_pkg::STATUS_W-1:0]      status,
    output logic [keht_pkg::POS_W-1:0]         position,
    output logic [keht_pkg::KEY_W-1:0]         key_out,
    output logic [keht_pkg::SLOT_W-1:0]        window_slot,
    output logic [keht_pkg::CNT_W-1:0]         type0_count,
    output logic [keht_pkg::CNT_W-1:0]         type1_count,
    output logic [keht_pkg::CNT_W-1:0]         type2_count,
    output logic [keht_pkg::CNT_W-1:0]         type3_count,
    output logic [keht_pkg::CNT_W-1:0]         total_count,
    output logic [keht_pkg::CNT_W-1:0]         bought_count,
    output logic                               qualifies,
    output logic                               is_last
);
    import keht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int UW = AW + 1;
    localparam int EW = AW + POS_W;
    localparam int WL = (NUM_WINDOWS > WSLOTS) ? WSLOTS : NUM_WINDOWS;
    localparam int TL = (NUM_TYPES > TSLOTS) ? TSLOTS : NUM_TYPES;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WL - 1);
    localparam logic [UW-1:0]     DEPTH_U   = UW'(TABLE_DEPTH);
    localparam logic [TYPE_W:0]   TL_U      = (TYPE_W + 1)'(TL);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_SEARCH   = 8'b0000_0010,
        ST_CLEAR    = 8'b0000_0100,
        ST_UPD_RD   = 8'b0000_1000,
        ST_UPD_WR   = 8'b0001_0000,
        ST_RD_ISSUE = 8'b0010_0000,
        ST_RD_EMIT  = 8'b0100_0000,
        ST_ERR      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [DATE_W-1:0]  bound_reg [WSLOTS];
    logic [TYPE_W-1:0]  bought_code_reg;
    logic [FLOOR_W-1:0] total_floor_reg;

    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TYPE_W-1:0]   type_reg, type_next;
    logic [POS_W-1:0]    ridx_reg, ridx_next;
    logic                has_win_reg, has_win_next;
    logic [SLOT_W-1:0]   win_reg, win_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       scan_reg, scan_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [UW-1:0]       used_reg, used_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic [KEY_W-1:0]    key_out_reg, key_out_next;
    logic [SLOT_W-1:0]   slot_out_reg, slot_out_next;
    win_row_t            row_out_reg, row_out_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    bought_reg, bought_next;
    logic                qual_reg, qual_next;
    logic                last_reg, last_next;

    logic out_free;
    logic out_load;
    logic in_fire;

    logic [EW-1:0] ridx_ext;
    logic [EW-1:0] used_ext;
    logic [EW-1:0] pos_ext;
    logic          read_bad;
    logic          sel_hit;
    logic [SLOT_W-1:0] sel_win;
    logic [UW-1:0] scan_inc;

    store_we_t        st_we;
    logic [AW-1:0]    key_raddr;
    logic [KEY_W-1:0] key_rdata;
    logic [CNT_W-1:0] tot_wdata, bgt_wdata, tot_rdata, bgt_rdata;
    logic [AW+1:0]    win_addr;
    win_row_t         win_wdata, win_rdata;
    logic [SLOT_W-1:0] win_sel;

    logic [CNT_W-1:0] tot_new, bgt_new;
    win_row_t         row_new;
    logic             count_win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg[0]    <= BOUND_A_RST;
            bound_reg[1]    <= BOUND_B_RST;
            bound_reg[2]    <= BOUND_C_RST;
            bound_reg[3]    <= BOUND_D_RST;
            bought_code_reg <= BOUGHT_CODE_RST;
            total_floor_reg <= TOTAL_FLOOR_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_BOUND_A:     bound_reg[0]    <= cfg_data;
                REG_BOUND_B:     bound_reg[1]    <= cfg_data;
                REG_BOUND_C:     bound_reg[2]    <= cfg_data;
                REG_BOUND_D:     bound_reg[3]    <= cfg_data;
                REG_BOUGHT_CODE: bought_code_reg <= cfg_data[TYPE_W-1:0];
                REG_TOTAL_FLOOR: total_floor_reg <= cfg_data[FLOOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The lowest window whose bound lies above the date wins.
    always_comb
    begin
        sel_hit = 1'b0;
        sel_win = '0;
        for (int i = WL - 1; i >= 0; i--)
        begin
            if (event_date < bound_reg[i])
            begin
                sel_hit = 1'b1;
                sel_win = SLOT_W'(i);
            end
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign ridx_ext = {{AW{1'b0}}, read_index};
    assign used_ext = {{(EW - UW){1'b0}}, used_reg};
    assign pos_ext  = {{POS_W{1'b0}}, pos_reg};
    assign read_bad = (ridx_ext >= used_ext);
    assign scan_inc = {1'b0, scan_reg} + UW'(1);

    assign count_win = has_win_reg && ({1'b0, type_reg} < TL_U);

    always_comb
    begin
        tot_new = sat_inc(tot_rdata);
        bgt_new = (type_reg == bought_code_reg) ? sat_inc(bgt_rdata) : bgt_rdata;
        row_new = win_rdata;
        if (count_win)
        begin
            row_new[type_reg] = sat_inc(win_rdata[type_reg]);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        type_next     = type_reg;
        ridx_next     = ridx_reg;
        has_win_next  = has_win_reg;
        win_next      = win_reg;
        pos_next      = pos_reg;
        scan_next     = scan_reg;
        slot_next     = slot_reg;
        err_next      = err_reg;
        used_next     = used_reg;
        out_load      = 1'b0;
        status_next   = STATUS_OK;
        position_next = '0;
        key_out_next  = '0;
        slot_out_next = '0;
        row_out_next  = '0;
        total_next    = '0;
        bought_next   = '0;
        qual_next     = 1'b0;
        last_next     = 1'b1;
        st_we         = '0;
        tot_wdata     = '0;
        bgt_wdata     = '0;
        win_wdata     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_next     = item_key;
                    type_next    = action_type;
                    ridx_next    = read_index;
                    has_win_next = sel_hit;
                    win_next     = sel_win;
                    scan_next    = '0;
                    slot_next    = '0;
                    if (func == FUNC_READ)
                    begin
                        pos_next = ridx_ext[AW-1:0];
                        if (read_bad)
                        begin
                            err_next   = STATUS_UNUSED;
                            state_next = ST_ERR;
                        end
                        else
                        begin
                            state_next = ST_RD_ISSUE;
                        end
                    end
                    else if (used_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (key_rdata == key_reg)
                begin
                    pos_next   = scan_reg;
                    state_next = ST_UPD_RD;
                end
                else if (scan_inc == used_reg)
                begin
                    if (used_reg == DEPTH_U)
                    begin
                        err_next   = STATUS_FULL;
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        pos_next   = used_reg[AW-1:0];
                        state_next = ST_CLEAR;
                    end
                end
                else
                begin
                    scan_next = scan_inc[AW-1:0];
                end
            end
            ST_CLEAR:
            begin
                st_we.win_we = 1'b1;
                if (slot_reg == '0)
                begin
                    st_we.key_we = 1'b1;
                    st_we.cnt_we = 1'b1;
                    used_next    = used_reg + UW'(1);
                end
                if (slot_reg == LAST_SLOT)
                begin
                    state_next = ST_UPD_RD;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            ST_UPD_RD:
            begin
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                if (out_free)
                begin
                    st_we.cnt_we  = 1'b1;
                    st_we.win_we  = count_win;
                    tot_wdata     = tot_new;
                    bgt_wdata     = bgt_new;
                    win_wdata     = row_new;
                    out_load      = 1'b1;
                    position_next = pos_ext[POS_W-1:0];
                    key_out_next  = key_reg;
                    slot_out_next = has_win_reg ? win_reg : '0;
                    row_out_next  = has_win_reg ? row_new : '0;
                    total_next    = tot_new;
                    bought_next   = bgt_new;
                    qual_next     = (tot_new > CNT_W'(total_floor_reg)) || (bgt_new != '0);
                    state_next    = ST_IDLE;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_EMIT;
            end
            ST_RD_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    position_next = ridx_reg;
                    key_out_next  = key_rdata;
                    slot_out_next = slot_reg;
                    row_out_next  = win_rdata;
                    total_next    = tot_rdata;
                    bought_next   = bgt_rdata;
                    qual_next     = (tot_rdata > CNT_W'(total_floor_reg)) || (bgt_rdata != '0);
                    last_next     = (slot_reg == LAST_SLOT);
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = ST_RD_ISSUE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    status_next   = err_reg;
                    position_next = (err_reg == STATUS_UNUSED) ? ridx_reg : '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_SEARCH)
        begin
            key_raddr = scan_inc[AW-1:0];
        end
        else if (state_reg == ST_IDLE)
        begin
            key_raddr = '0;
        end
        else
        begin
            key_raddr = pos_reg;
        end
    end

    assign win_sel  = ((state_reg == ST_UPD_RD) || (state_reg == ST_UPD_WR)) ? win_reg : slot_reg;
    assign win_addr = {pos_reg, win_sel};

    keht_store #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_store (
        .clk       (clk),
        .we        (st_we),
        .key_raddr (key_raddr),
        .key_waddr (pos_reg),
        .key_wdata (key_reg),
        .key_rdata (key_rdata),
        .cnt_addr  (pos_reg),
        .tot_wdata (tot_wdata),
        .bgt_wdata (bgt_wdata),
        .tot_rdata (tot_rdata),
        .bgt_rdata (bgt_rdata),
        .win_addr  (win_addr),
        .win_wdata (win_wdata),
        .win_rdata (win_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        type_reg    <= type_next;
        ridx_reg    <= ridx_next;
        has_win_reg <= has_win_next;
        win_reg     <= win_next;
        pos_reg     <= pos_next;
        scan_reg    <= scan_next;
        slot_reg    <= slot_next;
        err_reg     <= err_next;
        if (out_load)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
            key_out_reg  <= key_out_next;
            slot_out_reg <= slot_out_next;
            row_out_reg  <= row_out_next;
            total_reg    <= total_next;
            bought_reg   <= bought_next;
            qual_reg     <= qual_next;
            last_reg     <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign position     = position_reg;
    assign key_out      = key_out_reg;
    assign window_slot  = slot_out_reg;
    assign type0_count  = row_out_reg[0];
    assign type1_count  = row_out_reg[1];
    assign type2_count  = row_out_reg[2];
    assign type3_count  = row_out_reg[3];
    assign total_count  = total_reg;
    assign bought_count = bought_reg;
    assign qualifies    = qual_reg;
    assign is_last      = last_reg;

endmodule

### sim/histogram_checker.sv
module histogram_checker
    import keht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  func,
    input  logic [KEY_W-1:0]      item_key,
    input  logic [TYPE_W-1:0]     action_type,
    input  logic [DATE_W-1:0]     event_date,
    input  logic [POS_W-1:0]      read_index,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [STATUS_W-1:0]   status,
    input  logic [POS_W-1:0]      position,
    input  logic [KEY_W-1:0]      key_out,
    input  logic [SLOT_W-1:0]     window_slot,
    input  logic [CNT_W-1:0]      type0_count,
    input  logic [CNT_W-1:0]      type1_count,
    input  logic [CNT_W-1:0]      type2_count,
    input  logic [CNT_W-1:0]      type3_count,
    input  logic [CNT_W-1:0]      total_count,
    input  logic [CNT_W-1:0]      bought_count,
    input  logic                  qualifies,
    input  logic                  is_last,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int WINDOWS = DEF_NUM_WINDOWS;

    typedef struct packed {
        logic [STATUS_W-1:0]          status;
        logic [POS_W-1:0]             position;
        logic [KEY_W-1:0]             key;
        logic [SLOT_W-1:0]            slot;
        logic [TSLOTS-1:0][CNT_W-1:0] counts;
        logic [CNT_W-1:0]             total;
        logic [CNT_W-1:0]             bought;
        logic                         qual;
        logic                         last;
    } hist_row_t;

    hist_row_t expected_rows[$];

    logic [DATE_W-1:0]  bound [WSLOTS];
    logic [TYPE_W-1:0]  bought_sel;
    logic [FLOOR_W-1:0] floor_val;
    int                 used;
    logic [KEY_W-1:0]   key_mem [DEPTH];
    logic [CNT_W-1:0]   total_mem [DEPTH];
    logic [CNT_W-1:0]   bought_mem [DEPTH];
    logic [CNT_W-1:0]   win_cnt [DEPTH][WSLOTS][TSLOTS];

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic hist_row_t entry_row(input int pos, input int win, input bit has_win);
        hist_row_t r;
        r = '0;
        r.status   = STATUS_OK;
        r.position = POS_W'(pos);
        r.key      = key_mem[pos];
        r.total    = total_mem[pos];
        r.bought   = bought_mem[pos];
        r.qual     = (total_mem[pos] > CNT_W'(floor_val)) || (bought_mem[pos] != '0);
        if (has_win)
        begin
            r.slot = SLOT_W'(win);
            for (int t = 0; t < DEF_NUM_TYPES; t++)
            begin
                r.counts[t] = win_cnt[pos][win][t];
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : model
        hist_row_t row;
        int        pos;
        int        win;
        bit        found;
        bit        has_win;
        if (!rst_n)
        begin
            bound[0]   = BOUND_A_RST;
            bound[1]   = BOUND_B_RST;
            bound[2]   = BOUND_C_RST;
            bound[3]   = BOUND_D_RST;
            bought_sel = BOUGHT_CODE_RST;
            floor_val  = TOTAL_FLOOR_RST;
            used       = 0;
            errors     = 0;
            expected_rows.delete();
            foreach (key_mem[i])
            begin
                key_mem[i]    = '0;
                total_mem[i]  = '0;
                bought_mem[i] = '0;
            end
            foreach (win_cnt[i, w, t])
            begin
                win_cnt[i][w][t] = '0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rows.size() == 0)
                begin
                    $error("result transaction with nothing expected: position %0d", position);
                    errors++;
                end
                else
                begin
                    row = expected_rows.pop_front();
                    check_field("status", CNT_W'(row.status), CNT_W'(status));
                    check_field("position", CNT_W'(row.position), CNT_W'(position));
                    check_field("key_out", CNT_W'(row.key), CNT_W'(key_out));
                    check_field("window_slot", CNT_W'(row.slot), CNT_W'(window_slot));
                    check_field("type0_count", row.counts[0], type0_count);
                    check_field("type1_count", row.counts[1], type1_count);
                    check_field("type2_count", row.counts[2], type2_count);
                    check_field("type3_count", row.counts[3], type3_count);
                    check_field("total_count", row.total, total_count);
                    check_field("bought_count", row.bought, bought_count);
                    check_field("qualifies", CNT_W'(row.qual), CNT_W'(qualifies));
                    check_field("is_last", CNT_W'(row.last), CNT_W'(is_last));
                end
            end

            if (in_valid && in_ready)
            begin
                if (func == FUNC_READ)
                begin
                    if (int'(read_index) >= used)
                    begin
                        row          = '0;
                        row.status   = STATUS_UNUSED;
                        row.position = read_index;
                        row.last     = 1'b1;
                        expected_rows.push_back(row);
                    end
                    else
                    begin
                        for (int w = 0; w < WINDOWS; w++)
                        begin
                            row      = entry_row(int'(read_index), w, 1'b1);
                            row.last = (w == WINDOWS - 1);
                            expected_rows.push_back(row);
                        end
                    end
                end
                else
                begin
                    found = 1'b0;
                    pos   = 0;
                    for (int i = 0; i < used; i++)
                    begin
                        if (!found && key_mem[i] == item_key)
                        begin
                            pos   = i;
                            found = 1'b1;
                        end
                    end
                    if (!found && used >= DEPTH)
                    begin
                        row        = '0;
                        row.status = STATUS_FULL;
                        row.last   = 1'b1;
                        expected_rows.push_back(row);
                    end
                    else
                    begin
                        if (!found)
                        begin
                            pos          = used;
                            key_mem[pos] = item_key;
                            used++;
                        end
                        total_mem[pos] = bump(total_mem[pos]);
                        if (action_type == bought_sel)
                        begin
                            bought_mem[pos] = bump(bought_mem[pos]);
                        end
                        has_win = 1'b0;
                        win     = 0;
                        for (int i = 0; i < WINDOWS; i++)
                        begin
                            if (!has_win && event_date < bound[i])
                            begin
                                win     = i;
                                has_win = 1'b1;
                            end
                        end
                        if (has_win && int'(action_type) < DEF_NUM_TYPES)
                        begin
                            win_cnt[pos][win][action_type] = bump(win_cnt[pos][win][action_type]);
                        end
                        row      = entry_row(pos, win, has_win);
                        row.last = 1'b1;
                        expected_rows.push_back(row);
                    end
                end
            end

            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_BOUND_A:     bound[0] = cfg_data;
                    REG_BOUND_B:     bound[1] = cfg_data;
                    REG_BOUND_C:     bound[2] = cfg_data;
                    REG_BOUND_D:     bound[3] = cfg_data;
                    REG_BOUGHT_CODE: bought_sel = cfg_data[TYPE_W-1:0];
                    REG_TOTAL_FLOOR: floor_val = cfg_data[FLOOR_W-1:0];
                    default:         ;
                endcase
            end
        end
        pending = expected_rows.size();
    end

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import keht_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int DEPTH        = DEF_TABLE_DEPTH;
    localparam int DATE_MAX     = 9999;
    localparam int POOL_SIZE    = 16;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = FUNC_RECORD;
    logic [KEY_W-1:0]      item_key = '0;
    logic [TYPE_W-1:0]     action_type = '0;
    logic [DATE_W-1:0]     event_date = '0;
    logic [POS_W-1:0]      read_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [POS_W-1:0]      position;
    logic [KEY_W-1:0]      key_out;
    logic [SLOT_W-1:0]     window_slot;
    logic [CNT_W-1:0]      type0_count;
    logic [CNT_W-1:0]      type1_count;
    logic [CNT_W-1:0]      type2_count;
    logic [CNT_W-1:0]      type3_count;
    logic [CNT_W-1:0]      total_count;
    logic [CNT_W-1:0]      bought_count;
    logic                  qualifies;
    logic                  is_last;
    int                    errors;
    int                    pending;

    bit                idle_on = 1'b1;
    int                hold_req = 0;
    int                cur_bound [WSLOTS];
    bit                key_seen [logic [KEY_W-1:0]];
    int                key_count = 0;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    keyed_event_histogram_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .item_key     (item_key),
        .action_type  (action_type),
        .event_date   (event_date),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .position     (position),
        .key_out      (key_out),
        .window_slot  (window_slot),
        .type0_count  (type0_count),
        .type1_count  (type1_count),
        .type2_count  (type2_count),
        .type3_count  (type3_count),
        .total_count  (total_count),
        .bought_count (bought_count),
        .qualifies    (qualifies),
        .is_last      (is_last)
    );

    histogram_checker hist_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .item_key     (item_key),
        .action_type  (action_type),
        .event_date   (event_date),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .position     (position),
        .key_out      (key_out),
        .window_slot  (window_slot),
        .type0_count  (type0_count),
        .type1_count  (type1_count),
        .type2_count  (type2_count),
        .type3_count  (type3_count),
        .total_count  (total_count),
        .bought_count (bought_count),
        .qualifies    (qualifies),
        .is_last      (is_last),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 95)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [DATE_W-1:0] rand_date();
        int d;
        if ($urandom_range(0, 1) == 0)
        begin
            d = $urandom_range(0, DATE_MAX);
        end
        else
        begin
            d = cur_bound[$urandom_range(0, WSLOTS - 1)] + int'($urandom_range(0, 2)) - 1;
        end
        if (d < 0)
        begin
            d = 0;
        end
        if (d > DATE_MAX)
        begin
            d = DATE_MAX;
        end
        return DATE_W'(d);
    endfunction

    task automatic send_item(input logic f, input logic [KEY_W-1:0] k,
                             input logic [TYPE_W-1:0] t, input logic [DATE_W-1:0] d,
                             input logic [POS_W-1:0] ri);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    = 1'b1;
        func        = f;
        item_key    = k;
        action_type = t;
        event_date  = d;
        read_index  = ri;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic record_event(input logic [KEY_W-1:0] k, input int t, input int d);
        if (!key_seen.exists(k) && key_count < DEPTH)
        begin
            key_seen[k] = 1'b1;
            key_count++;
        end
        send_item(FUNC_RECORD, k, TYPE_W'(t), DATE_W'(d), POS_W'($urandom));
    endtask

    task automatic read_entry(input int ri);
        send_item(FUNC_READ, KEY_W'($urandom), TYPE_W'($urandom), DATE_W'($urandom),
                  POS_W'(ri));
    endtask

    task automatic rand_items(input int n);
        int r;
        int hi;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                hi = (key_count + 1 > DEPTH - 1) ? DEPTH - 1 : key_count + 1;
                if ($urandom_range(0, 9) == 0)
                begin
                    read_entry($urandom_range(0, DEPTH - 1));
                end
                else
                begin
                    read_entry($urandom_range(0, hi));
                end
            end
            else if (r < 85)
            begin
                record_event(key_pool[$urandom_range(0, POOL_SIZE - 1)],
                             $urandom_range(0, 3), int'(rand_date()));
            end
            else
            begin
                record_event(KEY_W'($urandom), $urandom_range(0, 3), int'(rand_date()));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = CFG_DATA_W'(data);
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic set_config(input int a, input int b, input int c, input int d,
                              input int code, input int floor_v);
        write_reg(REG_BOUND_A, a);
        write_reg(REG_BOUND_B, b);
        write_reg(REG_BOUND_C, c);
        write_reg(REG_BOUND_D, d);
        write_reg(REG_BOUGHT_CODE, code);
        write_reg(REG_TOTAL_FLOOR, floor_v);
        cur_bound[0] = a;
        cur_bound[1] = b;
        cur_bound[2] = c;
        cur_bound[3] = d;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin : receiver
        int gap;
        int holds_done;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != holds_done)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done++;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    @(negedge clk);
                    out_ready = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int lo;
        int mid;
        cur_bound[0] = int'(BOUND_A_RST);
        cur_bound[1] = int'(BOUND_B_RST);
        cur_bound[2] = int'(BOUND_C_RST);
        cur_bound[3] = int'(BOUND_D_RST);
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            key_pool[i] = KEY_W'($urandom);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: empty-table reads, window boundaries, a date past every bound.
        read_entry(0);
        read_entry(DEPTH - 1);
        record_event('0, 0, 0);
        record_event('1, 3, DATE_MAX);
        record_event('1, 1, 515);
        record_event('1, 1, 516);
        record_event('1, 1, 615);
        record_event('1, 1, 616);
        record_event('1, 1, 715);
        record_event('1, 1, 716);
        record_event('1, 1, 815);
        record_event('1, 2, 816);
        record_event('0, 2, DATE_MAX);
        record_event(31'h2AAA_AAAA, 3, 700);
        record_event(31'h5555_5555, 0, 5000);
        read_entry(0);
        read_entry(1);
        read_entry(2);
        read_entry(3);
        read_entry(4);
        read_entry(10'h155);
        read_entry(10'h2AA);
        drain();

        // Bounds out of order, highest bought code, floor at zero.
        set_config(800, 300, DATE_MAX, 0, 3, 0);
        record_event('0, 3, 850);
        record_event('0, 3, DATE_MAX);
        record_event('0, 3, 100);
        read_entry(0);
        hold_req++;
        rand_items(35);
        drain();

        // Every bound at zero: no window is ever counted.
        idle_on = 1'b0;
        set_config(0, 0, 0, 0, 0, 255);
        rand_items(30);
        drain();

        idle_on = 1'b1;
        set_config(DATE_MAX, DATE_MAX, DATE_MAX, DATE_MAX, 2, $urandom_range(0, 255));
        record_event(key_pool[2], 2, DATE_MAX);
        record_event(key_pool[2], 2, DATE_MAX - 1);
        rand_items(35);
        drain();

        // Random windows with a long hold-off on the result side.
        lo  = $urandom_range(0, 3000);
        mid = $urandom_range(lo, 6000);
        set_config(lo, mid, $urandom_range(mid, DATE_MAX), DATE_MAX, 1, 1);
        hold_req++;
        for (int i = 0; i < 4; i++)
        begin
            record_event(KEY_W'(31'h6B00_0000 + i), $urandom_range(0, 3), int'(rand_date()));
        end
        record_event('0, 1, int'(rand_date()));
        record_event(31'h5A00_0000, 0, 0);
        read_entry(DEPTH - 1);
        read_entry(DEPTH - 2);
        read_entry(0);
        read_entry(512);
        rand_items(12);
        drain();

        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin : watchdog
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
